// File: sv/fee_pkg.sv
package fee_pkg;

  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] EscByte  = 8'h7D;
  localparam logic [7:0] EscOf7D  = 8'h01;
  localparam logic [7:0] EscOf7E  = 8'h02;
  localparam logic [7:0] ZeroByte = 8'h00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_first;
    logic       frame_last;
  } fee_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } fee_out_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic       first;
    logic       last;
    logic [7:0] data;
    logic [7:0] check;
  } fee_cmd_t;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == EscByte) || (b == FlagByte);
  endfunction

  function automatic logic [7:0] esc_code(input logic [7:0] b);
    return (b == EscByte) ? EscOf7D : EscOf7E;
  endfunction

endpackage

// File: sv/fee_front.sv
module fee_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  fee_pkg::fee_in_t in_item_i,
  output fee_pkg::fee_cmd_t cmd_o
);
  import fee_pkg::*;

  logic [7:0] xor_q, xor_d;
  logic [7:0] xor_next;

  assign xor_next = (in_item_i.frame_first ? ZeroByte : xor_q) ^ in_item_i.data_byte;

  always_comb begin
    xor_d = xor_q;
    if (accept_i) begin
      xor_d = in_item_i.frame_last ? ZeroByte : xor_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q <= ZeroByte;
    end else begin
      xor_q <= xor_d;
    end
  end

  assign cmd_o.first = in_item_i.frame_first;
  assign cmd_o.last  = in_item_i.frame_last;
  assign cmd_o.data  = in_item_i.data_byte;
  assign cmd_o.check = xor_next;

endmodule

// File: sv/fee_fifo.sv
module fee_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  fee_pkg::fee_cmd_t wr_data_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              rd_valid_o,
  output fee_pkg::fee_cmd_t rd_data_o
);
  import fee_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  fee_cmd_t        mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full_o     = (cnt_q == CW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth)) else $error("queue count overflow");
  a_no_wr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o) else $error("write into full queue");
  a_no_rd_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> rd_valid_o) else $error("read from empty queue");
`endif

endmodule

// File: sv/fee_back.sv
module fee_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  fee_pkg::fee_cmd_t cmd_i,
  output logic              cmd_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output fee_pkg::fee_out_t out_item_o
);
  import fee_pkg::*;

  localparam logic [2:0] S_OPEN  = 3'd0;
  localparam logic [2:0] S_DATA  = 3'd1;
  localparam logic [2:0] S_DATA2 = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_CHK2  = 3'd4;
  localparam logic [2:0] S_CLOSE = 3'd5;

  fee_cmd_t   cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic [2:0] st_q, st_d;
  fee_out_t   out_q, out_d;
  logic       out_valid_q, out_valid_d;

  logic       adv, emit, done, is_end;
  logic [7:0] byte_c;
  logic [2:0] st_nxt;

  assign adv  = !out_valid_q || pop_i;
  assign emit = cur_valid_q && adv;

  always_comb begin
    byte_c = FlagByte;
    st_nxt = S_DATA;
    done   = 1'b0;
    is_end = 1'b0;
    case (st_q)
      S_OPEN: begin
        byte_c = FlagByte;
        st_nxt = S_DATA;
      end
      S_DATA: begin
        if (needs_esc(cur_q.data)) begin
          byte_c = EscByte;
          st_nxt = S_DATA2;
        end else begin
          byte_c = cur_q.data;
          st_nxt = S_CHK;
          done   = !cur_q.last;
        end
      end
      S_DATA2: begin
        byte_c = esc_code(cur_q.data);
        st_nxt = S_CHK;
        done   = !cur_q.last;
      end
      S_CHK: begin
        if (needs_esc(cur_q.check)) begin
          byte_c = EscByte;
          st_nxt = S_CHK2;
        end else begin
          byte_c = cur_q.check;
          st_nxt = S_CLOSE;
        end
      end
      S_CHK2: begin
        byte_c = esc_code(cur_q.check);
        st_nxt = S_CLOSE;
      end
      S_CLOSE: begin
        byte_c = FlagByte;
        done   = 1'b1;
        is_end = 1'b1;
      end
      default: begin
        byte_c = FlagByte;
        done   = 1'b1;
      end
    endcase
  end

  assign cmd_pop_o = cmd_valid_i && (!cur_valid_q || (emit && done));

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    st_d        = st_q;
    if (emit) begin
      st_d = st_nxt;
      if (done) begin
        cur_valid_d = 1'b0;
      end
    end
    if (cmd_pop_o) begin
      cur_d       = cmd_i;
      cur_valid_d = 1'b1;
      st_d        = cmd_i.first ? S_OPEN : S_DATA;
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_d.out_byte  = byte_c;
      out_d.run_last  = done;
      out_d.frame_end = is_end;
      out_valid_d     = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      st_q        <= S_OPEN;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

`ifndef SYNTH
  a_end_is_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_end |-> out_q.run_last && out_q.out_byte == FlagByte)
    else $error("frame end not on closing flag");
  a_esc_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && (st_q == S_DATA2 || st_q == S_CHK2) |->
      out_valid_q && out_q.out_byte == EscByte)
    else $error("escape code without preceding escape byte");
  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.run_last |-> cur_valid_q)
    else $error("request dropped before its final byte");
`endif

endmodule

// File: sv/frame_escape_encoder_xor.sv
// Frame escape encoder with XOR check. Takes the unescaped bytes of a message
// (frame_first on the first, frame_last on the last) and delivers the framed
// stream one byte per pop: an opening 0x7E before a first byte, 0x7D sent as
// 7D 01, 0x7E as 7D 02, and after a last byte the escaped running XOR of the
// message bytes plus a closing 0x7E flagged by frame_end. run_last marks the
// final byte caused by each request. An input request produces 1 to 6 output
// bytes, paced by the single byte sequencer of the back end, which holds while
// output is not popped. The front classifies one request per cycle while the
// queue is not full into a Depth-entry queue, which can fill when requests
// produce several bytes each or when output lags.
module frame_escape_encoder_xor #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  fee_pkg::fee_in_t  in_item_i,
  output logic              empty,
  input  logic              pop,
  output fee_pkg::fee_out_t out_item_o
);
  import fee_pkg::*;

  logic     accept;
  fee_cmd_t front_cmd;
  logic     q_full;
  logic     q_valid;
  fee_cmd_t q_cmd;
  logic     q_pop;

  assign accept = push && !q_full;
  assign full   = q_full;

  fee_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_item_i (in_item_i),
    .cmd_o     (front_cmd)
  );

  fee_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (accept),
    .wr_data_i  (front_cmd),
    .full_o     (q_full),
    .rd_i       (q_pop),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_cmd)
  );

  fee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop && !empty),
    .out_item_o  (out_item_o)
  );

endmodule

// File: tb/fee_checker.sv
module fee_checker
  import fee_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  logic     full_i,
  input  fee_in_t  in_item_i,
  input  logic     empty_i,
  input  logic     pop_i,
  input  fee_out_t out_item_i,
  output int       mismatch_count_o,
  output int       bytes_outstanding_o
);

  logic [7:0] frame_xor;
  fee_out_t   burst_q[$];
  fee_out_t   framed_q[$];

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] %s: got %02h, want %02h", $realtime, field, got, want);
    mismatch_count_o++;
  endtask

  function automatic void add_byte(input logic [7:0] b, input logic end_mark);
    fee_out_t r;
    r.out_byte  = b;
    r.run_last  = 1'b0;
    r.frame_end = end_mark;
    burst_q.push_back(r);
  endfunction

  function automatic void add_escaped(input logic [7:0] b);
    if (b == EscByte) begin
      add_byte(EscByte, 1'b0);
      add_byte(EscOf7D, 1'b0);
    end else if (b == FlagByte) begin
      add_byte(EscByte, 1'b0);
      add_byte(EscOf7E, 1'b0);
    end else begin
      add_byte(b, 1'b0);
    end
  endfunction

  function automatic void encode_request(input fee_in_t req);
    fee_out_t r;
    burst_q.delete();
    if (req.frame_first) begin
      frame_xor = ZeroByte;
      add_byte(FlagByte, 1'b0);
    end
    frame_xor = frame_xor ^ req.data_byte;
    add_escaped(req.data_byte);
    if (req.frame_last) begin
      add_escaped(frame_xor);
      add_byte(FlagByte, 1'b1);
      frame_xor = ZeroByte;
    end
    foreach (burst_q[i]) begin
      r = burst_q[i];
      r.run_last = (i == burst_q.size() - 1);
      framed_q.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fee_out_t want;
    if (!rst_ni) begin
      frame_xor = ZeroByte;
      framed_q.delete();
      mismatch_count_o = 0;
      bytes_outstanding_o = 0;
    end else begin
      if (push_i && !full_i) begin
        encode_request(in_item_i);
      end
      if (pop_i && !empty_i) begin
        if (framed_q.size() == 0) begin
          report_mismatch("unexpected out_byte", out_item_i.out_byte, ZeroByte);
        end else begin
          want = framed_q.pop_front();
          if (out_item_i.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_item_i.out_byte, want.out_byte);
          if (out_item_i.run_last !== want.run_last)
            report_mismatch("run_last", 8'(out_item_i.run_last), 8'(want.run_last));
          if (out_item_i.frame_end !== want.frame_end)
            report_mismatch("frame_end", 8'(out_item_i.frame_end), 8'(want.frame_end));
        end
      end
      bytes_outstanding_o = framed_q.size();
    end
  end

endmodule

// File: tb/tb_frame_escape_encoder_xor.sv
module tb_frame_escape_encoder_xor;
  import fee_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     push;
  logic     full;
  fee_in_t  in_item;
  logic     empty;
  logic     pop;
  fee_out_t out_item;
  int       mismatch_count;
  int       bytes_outstanding;
  int       sent_count;
  int       popped_count;

  frame_escape_encoder_xor uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  fee_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (push),
    .full_i             (full),
    .in_item_i          (in_item),
    .empty_i            (empty),
    .pop_i              (pop),
    .out_item_i         (out_item),
    .mismatch_count_o   (mismatch_count),
    .bytes_outstanding_o(bytes_outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return EscByte;
    if (r == 1) return FlagByte;
    return 8'($urandom_range(0, 255));
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic [7:0] b, input logic first, input logic last);
    int gap;
    fee_in_t req;
    gap = (sent_count % 64 < 16) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.data_byte   = b;
    req.frame_first = first;
    req.frame_last  = last;
    push    <= 1'b1;
    in_item <= req;
    do @(posedge clk_i); while (full);
    sent_count++;
    @(negedge clk_i);
  endtask

  // receiver
  initial begin
    int stall;
    popped_count = 0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = (popped_count % 80 < 20) ? 0 : $urandom_range(0, 3);
      if (popped_count == 60 || popped_count == 400) stall = 120;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      popped_count++;
      @(negedge clk_i);
    end
  end

  // sender
  initial begin
    int random_sent;
    int len;
    int kind;
    sent_count = 0;
    random_sent = 0;
    push    <= 1'b0;
    in_item <= '0;
    rst_ni  <= 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // bytes with no open frame
    send_request(8'hA5, 1'b0, 1'b0);
    send_request(8'h3C, 1'b0, 1'b1);
    // one-byte frames
    send_request(8'h00, 1'b1, 1'b1);
    send_request(FlagByte, 1'b1, 1'b1);
    send_request(EscByte, 1'b1, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1);
    // escapes in the body
    send_request(EscByte, 1'b1, 1'b0);
    send_request(FlagByte, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h55, 1'b0, 1'b1);
    // check byte lands on a flag, then on an escape
    send_request(8'h12, 1'b1, 1'b0);
    send_request(8'h6C, 1'b0, 1'b1);
    send_request(8'h01, 1'b1, 1'b0);
    send_request(8'h7C, 1'b0, 1'b1);
    // restart inside an open frame
    send_request(8'h11, 1'b1, 1'b0);
    send_request(8'h22, 1'b0, 1'b0);
    send_request(8'h33, 1'b1, 1'b0);
    send_request(8'h44, 1'b0, 1'b1);
    // check byte of zero
    send_request(8'hAA, 1'b1, 1'b0);
    send_request(8'hAA, 1'b0, 1'b1);

    while (random_sent < 250) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_request(pick_byte(), i == 0, i == len - 1);
        end
        random_sent += len;
      end else if (kind == 8) begin
        send_request(pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        random_sent++;
      end else begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          send_request(pick_byte(), i == 0, 1'b0);
        end
        random_sent += len;
      end
    end
    push <= 1'b0;

    while (bytes_outstanding != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0 && bytes_outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
